// ===== sv/dram_bank_scheduler_frfcfs_unit_defines.svh =====
// Assertion macros for the FR-FCFS bank scheduler.
// Depends on nothing; included by the modules that assert.
`ifndef DRAM_BANK_SCHEDULER_FRFCFS_UNIT_DEFINES_SVH
`define DRAM_BANK_SCHEDULER_FRFCFS_UNIT_DEFINES_SVH
`define DBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/dbs_pkg.sv =====
// Package for the FR-FCFS bank scheduler: types, constants, codes.
// Depends on nothing.
`timescale 1ns / 1ps
package dbs_pkg;
    localparam int QUEUE_SLOTS_DEF = 64;
    localparam int NUM_BANKS = 8;
    localparam int NUM_ROWS_DEF = 8192;
    localparam int ROW_W = 13;
    localparam int COL_W = 10;
    localparam int BANK_W = 3;
    localparam int TGT_W = 27;
    localparam int TIME_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T_RCD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T_CL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_T_RAS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_T_RP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_T_BURST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_T_REFI = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_T_RFC = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0, CMD_ACT = 3'd1, CMD_PRE = 3'd2, CMD_RD = 3'd3, CMD_WR = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0, MODE_ACTIVE = 2'd1, MODE_PRE = 2'd2, MODE_REF = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_ISSUE, ST_MOVE, ST_OUT
    } state_t;

    typedef struct packed {
        logic                  keep_row;
        logic [7:0]            t_rcd;
        logic [7:0]            t_cl;
        logic [7:0]            t_ras;
        logic [7:0]            t_rp;
        logic [7:0]            t_burst;
        logic [15:0]           t_refi;
        logic [11:0]           t_rfc;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch input item
        logic enq;        // write enqueue slot
        logic tick;       // bank timing update
        logic scan_start;
        logic scan_step;
        logic issue;      // evaluate pick
        logic move;       // copy head into freed slot
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_enq;
        logic scan_done;
        logic need_move;
    } dp_sts_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic        is_write;
    } req_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [BANK_W-1:0] cmd_bank;
        logic [ROW_W-1:0]  cmd_row;
        logic [COL_W-1:0]  cmd_col;
        logic [31:0]       latency;
        logic [7:0]        refresh_start_mask;
        logic [7:0]        refresh_precharge_mask;
        logic              queue_full;
        logic              dropped;
    } res_t;
endpackage

// ===== sv/dbs_if.sv =====
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface dbs_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/dbs_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module dbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/dbs_ctrl.sv =====
// Sequencer of the FR-FCFS scheduler: accept, enqueue or scan, issue, move, output.
// Depends on dbs_pkg.
`timescale 1ns / 1ps
`include "dram_bank_scheduler_frfcfs_unit_defines.svh"
module dbs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dbs_pkg::dp_sts_t   sts,
    output dbs_pkg::dp_cmd_t   cmd
);
    import dbs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.is_enq)
                begin
                    cmd.enq = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.tick = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (sts.scan_done)
                begin
                    cmd.issue = 1'b1;
                    state_next = ST_MOVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_MOVE:
            begin
                if (sts.need_move)
                begin
                    cmd.move = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `DBS_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_valid && in_ready, state_reg == ST_SCAN)
    `DBS_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `DBS_ASSERT_NEXT(a_move_out, clk, rst_n, state_reg == ST_MOVE, state_reg == ST_OUT)
endmodule

// ===== sv/dbs_dp.sv =====
// Datapath of the FR-FCFS scheduler: queue RAMs, bank state, pick, result.
// Depends on dbs_pkg and dbs_ram.
`timescale 1ns / 1ps
`include "dram_bank_scheduler_frfcfs_unit_defines.svh"
module dbs_dp #(
    parameter int QUEUE_SLOTS = dbs_pkg::QUEUE_SLOTS_DEF,
    parameter int NUM_ROWS = dbs_pkg::NUM_ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dbs_pkg::cfg_t    cfg,
    input  logic             in_kind,
    input  logic [31:0]      in_addr,
    input  logic             in_is_write,
    input  dbs_pkg::dp_cmd_t cmd,
    output dbs_pkg::dp_sts_t sts,
    output dbs_pkg::res_t    res
);
    import dbs_pkg::*;

    localparam int PW = $clog2(QUEUE_SLOTS);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] FULL_AT = CW'(QUEUE_SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(QUEUE_SLOTS);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

    logic             kind_reg;
    logic [31:0]      addr_reg;
    logic             wr_reg;
    logic [PW-1:0]    head_reg, tail_reg, head_next, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TIME_W-1:0] now_reg, now_next;

    mode_t             mode_reg [NUM_BANKS];
    mode_t             mode_next [NUM_BANKS];
    logic [ROW_W-1:0]  orow_reg [NUM_BANKS];
    logic [ROW_W-1:0]  orow_next [NUM_BANKS];
    logic              rvalid_reg [NUM_BANKS];
    logic              rvalid_next [NUM_BANKS];
    logic [TIME_W-1:0] ready_reg [NUM_BANKS];
    logic [TIME_W-1:0] ready_next [NUM_BANKS];
    logic [TIME_W-1:0] act_reg [NUM_BANKS];
    logic [TIME_W-1:0] act_next [NUM_BANKS];
    logic [TIME_W-1:0] due_reg [NUM_BANKS];
    logic [TIME_W-1:0] due_next [NUM_BANKS];

    // scan
    logic [CW-1:0]     scan_i_reg, scan_i_next;    // issued read index
    logic              rd_v_reg, rd_v_next;        // read data valid next cycle
    logic [PW-1:0]     rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic              top_hit_reg, top_hit_next;
    logic [PW-1:0]     best_reg, best_next;
    logic [TIME_W-1:0] top_arrival_reg, top_arrival_next;
    logic [TGT_W-1:0]  best_tgt_reg, best_tgt_next;
    logic              do_move_reg, do_move_next;
    logic [PW-1:0]     move_dst_reg, move_dst_next;
    res_t              res_reg, res_next;

    // RAM ports
    logic              ram_we;
    logic [PW-1:0]     ram_waddr, ram_raddr;
    logic [TGT_W-1:0]  tgt_wdata, tgt_rdata;
    logic [TIME_W-1:0] arr_wdata, arr_rdata;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    dbs_ram #(.WIDTH(TGT_W), .DEPTH(QUEUE_SLOTS)) u_tgt (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(tgt_wdata),
        .raddr(ram_raddr), .rdata(tgt_rdata)
    );
    dbs_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_SLOTS)) u_arr (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(arr_wdata),
        .raddr(ram_raddr), .rdata(arr_rdata)
    );

    logic [25:0]      cl;
    logic [ROW_W-1:0] enq_row;
    logic             full_now;
    assign cl = addr_reg[31:6];
    assign enq_row = cl[25:13] & ROW_W'(NUM_ROWS - 1);
    assign full_now = count_reg >= FULL_AT;

    // scan read address: head plus offset, wrapped at the queue depth
    logic [CW-1:0] rd_off;
    logic [CW-1:0] scan_sum;
    logic [PW-1:0] scan_addr;
    assign rd_off = cmd.scan_start ? '0 : scan_i_reg;
    assign scan_sum = CW'(head_reg) + rd_off;
    assign scan_addr = (scan_sum >= SLOTS_C) ? PW'(scan_sum - SLOTS_C) : PW'(scan_sum);

    always_comb
    begin
        ram_raddr = scan_addr;
        if (cmd.issue)
        begin
            ram_raddr = head_reg;
        end
        ram_we = 1'b0;
        ram_waddr = tail_reg;
        tgt_wdata = {wr_reg, enq_row, cl[12:3], cl[2:0]};
        arr_wdata = now_reg;
        if (cmd.enq && !full_now)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.move)
        begin
            ram_we = 1'b1;
            ram_waddr = move_dst_reg;
            tgt_wdata = tgt_rdata;
            arr_wdata = arr_rdata;
        end
    end

    // hit test for the entry being read
    logic [BANK_W-1:0] rb;
    logic              r_hit;
    assign rb = tgt_rdata[2:0];
    assign r_hit = mode_reg[rb] == MODE_ACTIVE && rvalid_reg[rb]
                   && orow_reg[rb] == tgt_rdata[25:13];

    logic take;
    assign take = !found_reg || (r_hit && !top_hit_reg)
                  || (r_hit == top_hit_reg && arr_rdata < top_arrival_reg);

    // tick bank update on now+1
    logic [TIME_W-1:0] nt;
    assign nt = now_reg + 64'd1;

    // issue evaluation
    logic [BANK_W-1:0] bb;
    logic [ROW_W-1:0]  brow;
    logic              b_hit, ras_ok;
    assign bb = best_tgt_reg[2:0];
    assign brow = best_tgt_reg[25:13];
    assign b_hit = mode_reg[bb] == MODE_ACTIVE && rvalid_reg[bb] && orow_reg[bb] == brow;
    assign ras_ok = now_reg >= act_reg[bb] + TIME_W'(cfg.t_ras);
    logic [TIME_W-1:0] dlat;
    assign dlat = now_reg - top_arrival_reg;

    assign sts.is_enq = kind_reg;
    assign sts.scan_done = !rd_v_reg && (scan_i_reg >= count_reg);
    assign sts.need_move = do_move_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            addr_reg <= in_addr;
            wr_reg <= in_is_write;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        now_next = now_reg;
        scan_i_next = scan_i_reg;
        rd_v_next = rd_v_reg;
        rd_idx_next = rd_idx_reg;
        found_next = found_reg;
        top_hit_next = top_hit_reg;
        best_next = best_reg;
        top_arrival_next = top_arrival_reg;
        best_tgt_next = best_tgt_reg;
        do_move_next = do_move_reg;
        move_dst_next = move_dst_reg;
        res_next = res_reg;
        mode_next = mode_reg;
        orow_next = orow_reg;
        rvalid_next = rvalid_reg;
        ready_next = ready_reg;
        act_next = act_reg;
        due_next = due_reg;

        if (cmd.enq)
        begin
            res_next = '0;
            if (full_now)
            begin
                res_next.dropped = 1'b1;
                res_next.queue_full = 1'b1;
            end
            else
            begin
                tail_next = ptr_inc(tail_reg);
                count_next = count_reg + CW'(1);
                res_next.queue_full = (count_reg + CW'(1)) >= FULL_AT;
            end
        end

        if (cmd.tick)
        begin
            res_next = '0;
            now_next = nt;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                if (nt >= due_reg[b])
                begin
                    if (mode_reg[b] == MODE_ACTIVE && nt >= act_reg[b] + TIME_W'(cfg.t_ras))
                    begin
                        mode_next[b] = MODE_PRE;
                        ready_next[b] = nt + TIME_W'(cfg.t_rp);
                        rvalid_next[b] = 1'b0;
                        orow_next[b] = '0;
                        res_next.refresh_precharge_mask[b] = 1'b1;
                    end
                    else if (mode_reg[b] == MODE_IDLE)
                    begin
                        mode_next[b] = MODE_REF;
                        ready_next[b] = nt + TIME_W'(cfg.t_rfc);
                        due_next[b] = nt + TIME_W'(cfg.t_refi);
                        res_next.refresh_start_mask[b] = 1'b1;
                    end
                end
                if ((mode_next[b] == MODE_PRE || mode_next[b] == MODE_REF)
                    && nt >= ready_next[b])
                begin
                    mode_next[b] = MODE_IDLE;
                end
            end
            scan_i_next = CW'(1);
            rd_v_next = count_reg != '0;
            rd_idx_next = head_reg;
            found_next = 1'b0;
            top_hit_next = 1'b0;
            do_move_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            if (rd_v_reg && take)
            begin
                found_next = 1'b1;
                top_hit_next = r_hit;
                best_next = rd_idx_reg;
                top_arrival_next = arr_rdata;
                best_tgt_next = tgt_rdata;
            end
            rd_v_next = scan_i_reg < count_reg;
            rd_idx_next = scan_addr;
            if (scan_i_reg < count_reg)
            begin
                scan_i_next = scan_i_reg + CW'(1);
            end
        end

        if (cmd.issue)
        begin
            res_next.queue_full = full_now;
            if (found_reg && mode_reg[bb] != MODE_PRE && mode_reg[bb] != MODE_REF)
            begin
                if (b_hit)
                begin
                    if (now_reg >= ready_reg[bb])
                    begin
                        res_next.cmd = best_tgt_reg[26] ? CMD_WR : CMD_RD;
                        res_next.cmd_bank = bb;
                        res_next.cmd_row = brow;
                        res_next.cmd_col = best_tgt_reg[12:3];
                        res_next.latency = (dlat[63:32] != '0) ? 32'hFFFF_FFFF : dlat[31:0];
                        ready_next[bb] = now_reg + TIME_W'(cfg.t_cl) + TIME_W'(cfg.t_burst);
                        if (!cfg.keep_row && ras_ok)
                        begin
                            mode_next[bb] = MODE_PRE;
                            ready_next[bb] = now_reg + TIME_W'(cfg.t_rp);
                            rvalid_next[bb] = 1'b0;
                            orow_next[bb] = '0;
                        end
                        do_move_next = 1'b1;
                        move_dst_next = best_reg;
                        head_next = ptr_inc(head_reg);
                        count_next = count_reg - CW'(1);
                        res_next.queue_full = (count_reg - CW'(1)) >= FULL_AT;
                    end
                end
                else if (mode_reg[bb] == MODE_ACTIVE)
                begin
                    if (ras_ok)
                    begin
                        res_next.cmd = CMD_PRE;
                        res_next.cmd_bank = bb;
                        res_next.cmd_row = orow_reg[bb];
                        mode_next[bb] = MODE_PRE;
                        ready_next[bb] = now_reg + TIME_W'(cfg.t_rp);
                        rvalid_next[bb] = 1'b0;
                        orow_next[bb] = '0;
                    end
                end
                else
                begin
                    res_next.cmd = CMD_ACT;
                    res_next.cmd_bank = bb;
                    res_next.cmd_row = brow;
                    mode_next[bb] = MODE_ACTIVE;
                    orow_next[bb] = brow;
                    rvalid_next[bb] = 1'b1;
                    act_next[bb] = now_reg;
                    ready_next[bb] = now_reg + TIME_W'(cfg.t_rcd);
                end
            end
        end

        if (cmd.move)
        begin
            do_move_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            now_reg <= '0;
            scan_i_reg <= '0;
            rd_v_reg <= 1'b0;
            rd_idx_reg <= '0;
            found_reg <= 1'b0;
            top_hit_reg <= 1'b0;
            best_reg <= '0;
            top_arrival_reg <= '0;
            best_tgt_reg <= '0;
            do_move_reg <= 1'b0;
            move_dst_reg <= '0;
            res_reg <= '0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                mode_reg[b] <= MODE_IDLE;
                orow_reg[b] <= '0;
                rvalid_reg[b] <= 1'b0;
                ready_reg[b] <= '0;
                act_reg[b] <= '0;
                due_reg[b] <= 64'd7800;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            now_reg <= now_next;
            scan_i_reg <= scan_i_next;
            rd_v_reg <= rd_v_next;
            rd_idx_reg <= rd_idx_next;
            found_reg <= found_next;
            top_hit_reg <= top_hit_next;
            best_reg <= best_next;
            top_arrival_reg <= top_arrival_next;
            best_tgt_reg <= best_tgt_next;
            do_move_reg <= do_move_next;
            move_dst_reg <= move_dst_next;
            res_reg <= res_next;
            mode_reg <= mode_next;
            orow_reg <= orow_next;
            rvalid_reg <= rvalid_next;
            ready_reg <= ready_next;
            act_reg <= act_next;
            due_reg <= due_next;
        end
    end

    `DBS_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= FULL_AT)
    `DBS_ASSERT_IMPL(a_drop_full, clk, rst_n, res_reg.dropped, res_reg.queue_full)
    `DBS_ASSERT_NEXT(a_enq_step, clk, rst_n, cmd.enq && !full_now,
        count_reg == $past(count_reg) + CW'(1))
endmodule

// ===== sv/dram_bank_scheduler_frfcfs_unit.sv =====
// FR-FCFS DRAM bank scheduler for one rank of eight banks.
// Input channel in (kind, addr, is_write): kind 1 enqueues a request, kind 0
// is one controller tick. Output channel out carries one result per request:
// cmd with bank/row/col, latency, refresh masks, queue_full and dropped.
// Configuration: cfg_we, cfg_index, cfg_data write the timing registers;
// write them only while no request is in flight.
// The pending queue is a RAM with one read port, scanned one entry per cycle
// to pick row hits first, then the oldest; when a read or write is issued, the
// picked slot is refilled from the head entry. One request is in flight at a
// time; a new request is accepted only after the result of the last is taken.
// Reset: queue empty, all banks idle, tick count zero, refresh due at 7800,
// registers at their defaults. No clearing pass is needed.
// When out is stalled the result holds and no new request is accepted.
`timescale 1ns / 1ps
module dram_bank_scheduler_frfcfs_unit #(
    parameter int QUEUE_SLOTS = dbs_pkg::QUEUE_SLOTS_DEF,
    parameter int NUM_ROWS = dbs_pkg::NUM_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dbs_if.sink                                in,
    dbs_if.source                              out,
    input  logic                               cfg_we,
    input  logic [dbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dbs_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  dcmd;
    dp_sts_t  dsts;
    res_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_row <= 1'b1;
            cfg_reg.t_rcd <= 8'd14;
            cfg_reg.t_cl <= 8'd14;
            cfg_reg.t_ras <= 8'd33;
            cfg_reg.t_rp <= 8'd14;
            cfg_reg.t_burst <= 8'd4;
            cfg_reg.t_refi <= 16'd7800;
            cfg_reg.t_rfc <= 12'd350;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEEP_ROW:  cfg_reg.keep_row <= cfg_data[0];
                REG_T_RCD:     cfg_reg.t_rcd <= cfg_data[7:0];
                REG_T_CL:      cfg_reg.t_cl <= cfg_data[7:0];
                REG_T_RAS:     cfg_reg.t_ras <= cfg_data[7:0];
                REG_T_RP:      cfg_reg.t_rp <= cfg_data[7:0];
                REG_T_BURST:   cfg_reg.t_burst <= cfg_data[7:0];
                REG_T_REFI:    cfg_reg.t_refi <= cfg_data;
                REG_T_RFC:     cfg_reg.t_rfc <= cfg_data[11:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    dbs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_ready(in.ready),
        .out_valid(out.valid), .out_ready(out.ready),
        .sts(dsts), .cmd(dcmd)
    );

    dbs_dp #(.QUEUE_SLOTS(QUEUE_SLOTS), .NUM_ROWS(NUM_ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_kind(in.data.kind), .in_addr(in.data.addr), .in_is_write(in.data.is_write),
        .cmd(dcmd), .sts(dsts), .res(res)
    );

    assign out.data = res;
endmodule
